// ----- rtl/lcma_pkg.sv -----
// lcma_pkg: types shared by the LCM accumulator controller, datapath and top level.
// No dependencies.
package lcma_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_GCD,
      ST_GCD_CHK,
      ST_QUO,
      ST_MUL,
      ST_DONE
   } state_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_DIV_GCD,
      OP_GCD_STEP,
      OP_DIV_QUO,
      OP_MUL_START,
      OP_MUL_STEP,
      OP_COMMIT_LOAD,
      OP_COMMIT_ZERO,
      OP_COMMIT_MUL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic first;         // captured item starts a new run
      logic zero_operand;  // accumulator or captured value is zero
      logic div_done;      // divider finished this cycle
      logic y_zero;        // Euclid remainder reached zero
      logic mul_done;      // shift-add multiply finished
      logic out_free;      // output register can take a result
   } dp_status_type;

endpackage

// ----- rtl/lcma_div.sv -----
// lcma_div: restoring divider, one quotient bit per cycle.
// Standalone; used by lcma_datapath.
module lcma_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic [DW-1:0] remainder,
   output logic          done
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [DW:0]   shifted;
   logic [DW:0]   diff;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // no borrow: shifted partial remainder covers the divisor
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

`ifndef NO_ASSERTIONS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0)
      else $error("divider started with zero divisor");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

// ----- rtl/lcma_datapath.sv -----
// lcma_datapath: accumulator, Euclid operands, shift-add multiplier and result register.
// Depends on lcma_pkg and lcma_div.
module lcma_datapath #(
   parameter int VALUE_WIDTH = 32,
   parameter int ACC_WIDTH   = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [VALUE_WIDTH-1:0]   req_value,
   input  logic                     req_first,
   input  lcma_pkg::dp_cmd_type     cmd,
   output lcma_pkg::dp_status_type  status,
   output logic [ACC_WIDTH-1:0]     rsp_lcm_value,
   output logic                     rsp_overflow,
   output logic                     rsp_valid,
   input  logic                     rsp_stall
);

   localparam int DW  = (VALUE_WIDTH > ACC_WIDTH) ? VALUE_WIDTH : ACC_WIDTH;
   localparam int PW  = ACC_WIDTH + VALUE_WIDTH;
   localparam int MCW = $clog2(VALUE_WIDTH + 1);
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   first_ff, first_in;
   logic [DW-1:0]          x_ff, x_in;
   logic [DW-1:0]          y_ff, y_in;
   logic [ACC_WIDTH-1:0]   q_ff, q_in;
   logic [VALUE_WIDTH-1:0] mb_ff, mb_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [MCW-1:0]         mcnt_ff, mcnt_in;
   logic [ACC_WIDTH-1:0]   out_val_ff, out_val_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic                   out_vld_ff, out_vld_in;

   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic [DW-1:0] div_quotient;
   logic [DW-1:0] div_remainder;
   logic          div_done;

   logic          load_over;
   logic          prod_over;

   assign div_start    = (cmd.op == lcma_pkg::OP_DIV_GCD) || (cmd.op == lcma_pkg::OP_DIV_QUO);
   assign div_dividend = (cmd.op == lcma_pkg::OP_DIV_QUO) ? DW'(acc_ff) : x_ff;
   assign div_divisor  = (cmd.op == lcma_pkg::OP_DIV_QUO) ? x_ff : y_ff;

   lcma_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // first value wider than the accumulator
   assign load_over = DW'(val_ff) > DW'(ACC_MAX);
   assign prod_over = prod_ff[PW-1:ACC_WIDTH] != '0;

   always_comb begin
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      val_in     = val_ff;
      first_in   = first_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      q_in       = q_ff;
      mb_in      = mb_ff;
      prod_in    = prod_ff;
      mcnt_in    = mcnt_ff;
      out_val_in = out_val_ff;
      out_ovf_in = out_ovf_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      case (cmd.op)
         lcma_pkg::OP_CAPTURE: begin
            val_in   = req_value;
            first_in = req_first;
            x_in     = DW'(acc_ff);
            y_in     = DW'(req_value);
         end
         lcma_pkg::OP_GCD_STEP: begin
            x_in = y_ff;
            y_in = div_remainder;
         end
         lcma_pkg::OP_MUL_START: begin
            q_in    = div_quotient[ACC_WIDTH-1:0];
            mb_in   = val_ff;
            prod_in = '0;
            mcnt_in = MCW'(VALUE_WIDTH);
         end
         lcma_pkg::OP_MUL_STEP: begin
            prod_in = (prod_ff << 1) + (mb_ff[VALUE_WIDTH-1] ? PW'(q_ff) : PW'(0));
            mb_in   = mb_ff << 1;
            mcnt_in = mcnt_ff - MCW'(1);
         end
         lcma_pkg::OP_COMMIT_LOAD: begin
            acc_in = load_over ? ACC_MAX : ACC_WIDTH'(val_ff);
            ovf_in = load_over;
         end
         lcma_pkg::OP_COMMIT_ZERO: begin
            acc_in = '0;
         end
         lcma_pkg::OP_COMMIT_MUL: begin
            acc_in = prod_over ? ACC_MAX : prod_ff[ACC_WIDTH-1:0];
            ovf_in = ovf_ff || prod_over;
         end
         default: begin
         end
      endcase
      if ((cmd.op == lcma_pkg::OP_COMMIT_LOAD) || (cmd.op == lcma_pkg::OP_COMMIT_ZERO) ||
          (cmd.op == lcma_pkg::OP_COMMIT_MUL)) begin
         out_val_in = acc_in;
         out_ovf_in = ovf_in;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         ovf_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
         mcnt_ff    <= '0;
      end else begin
         acc_ff     <= acc_in;
         ovf_ff     <= ovf_in;
         out_vld_ff <= out_vld_in;
         mcnt_ff    <= mcnt_in;
      end
      val_ff     <= val_in;
      first_ff   <= first_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      q_ff       <= q_in;
      mb_ff      <= mb_in;
      prod_ff    <= prod_in;
      out_val_ff <= out_val_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign status.first        = first_ff;
   assign status.zero_operand = (acc_ff == '0) || (val_ff == '0);
   assign status.div_done     = div_done;
   assign status.y_zero       = (y_ff == '0);
   assign status.mul_done     = (mcnt_ff == '0);
   assign status.out_free     = !out_vld_ff || !rsp_stall;

   assign rsp_lcm_value = out_val_ff;
   assign rsp_overflow  = out_ovf_ff;
   assign rsp_valid     = out_vld_ff;

endmodule

// ----- rtl/lcma_ctrl.sv -----
// lcma_ctrl: sequencing state machine for the LCM accumulator.
// Depends on lcma_pkg.
module lcma_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lcma_pkg::dp_status_type  status,
   output lcma_pkg::dp_cmd_type     cmd
);

   lcma_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcma_pkg::ST_IDLE: begin
            if (req_valid) state_in = lcma_pkg::ST_DECIDE;
         end
         lcma_pkg::ST_DECIDE: begin
            if (status.first || status.zero_operand) begin
               if (status.out_free) state_in = lcma_pkg::ST_IDLE;
            end else begin
               state_in = lcma_pkg::ST_GCD;
            end
         end
         lcma_pkg::ST_GCD: begin
            if (status.div_done) state_in = lcma_pkg::ST_GCD_CHK;
         end
         lcma_pkg::ST_GCD_CHK: begin
            state_in = status.y_zero ? lcma_pkg::ST_QUO : lcma_pkg::ST_GCD;
         end
         lcma_pkg::ST_QUO: begin
            if (status.div_done) state_in = lcma_pkg::ST_MUL;
         end
         lcma_pkg::ST_MUL: begin
            if (status.mul_done) state_in = lcma_pkg::ST_DONE;
         end
         lcma_pkg::ST_DONE: begin
            if (status.out_free) state_in = lcma_pkg::ST_IDLE;
         end
         default: state_in = lcma_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = lcma_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         lcma_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = lcma_pkg::OP_CAPTURE;
         end
         lcma_pkg::ST_DECIDE: begin
            if (status.first) begin
               if (status.out_free) cmd.op = lcma_pkg::OP_COMMIT_LOAD;
            end else if (status.zero_operand) begin
               if (status.out_free) cmd.op = lcma_pkg::OP_COMMIT_ZERO;
            end else begin
               cmd.op = lcma_pkg::OP_DIV_GCD;
            end
         end
         lcma_pkg::ST_GCD: begin
            if (status.div_done) cmd.op = lcma_pkg::OP_GCD_STEP;
         end
         lcma_pkg::ST_GCD_CHK: begin
            cmd.op = status.y_zero ? lcma_pkg::OP_DIV_QUO : lcma_pkg::OP_DIV_GCD;
         end
         lcma_pkg::ST_QUO: begin
            if (status.div_done) cmd.op = lcma_pkg::OP_MUL_START;
         end
         lcma_pkg::ST_MUL: begin
            if (!status.mul_done) cmd.op = lcma_pkg::OP_MUL_STEP;
         end
         lcma_pkg::ST_DONE: begin
            if (status.out_free) cmd.op = lcma_pkg::OP_COMMIT_MUL;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lcm_accumulator.sv -----
// lcm_accumulator: top level of the running least-common-multiple block.
// Depends on lcma_pkg, lcma_ctrl and lcma_datapath (which holds lcma_div).
//
// Folds a stream of unsigned values into their least common multiple. An item
// with req_first set loads the accumulator with its value and clears the
// overflow flag; every other item replaces the accumulator with
// (acc / gcd(acc, value)) * value, or with zero when either operand is zero.
// A product that does not fit in ACC_WIDTH bits saturates to all ones and sets
// rsp_overflow, which stays set until the next first item. Each item yields
// exactly one result transfer. One item is worked on at a time: req_stall is
// low only while the controller is idle, and a result waiting in the output
// register does not block the next input transfer. The divider is
// DW = max(VALUE_WIDTH, ACC_WIDTH) bits wide. A first item or a zero operand is
// committed to the result register from the decide state, once the output
// register is free; any other item first runs the Euclid remainder steps,
// the quotient and the multiply. The next input transfer can come in the cycle
// after the result register is loaded, and a result held by rsp_stall delays
// that load. The one-bit-per-cycle restoring divider is shared: it runs
// once per Euclid step and once more for acc / gcd, and the multiply is a
// shift-add over the value bits.
module lcm_accumulator #(
   parameter int VALUE_WIDTH = 32,
   parameter int ACC_WIDTH   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_first,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ACC_WIDTH-1:0]   rsp_lcm_value,
   output logic                   rsp_overflow
);

   lcma_pkg::dp_cmd_type    cmd;
   lcma_pkg::dp_status_type status;

   // sequencer: issues at most one datapath operation per cycle
   lcma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulator, Euclid operands, divider, multiplier and result register
   lcma_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_first     (req_first),
      .cmd           (cmd),
      .status        (status),
      .rsp_lcm_value (rsp_lcm_value),
      .rsp_overflow  (rsp_overflow),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall)
   );

`ifndef NO_ASSERTIONS
   // one item in flight: an input transfer closes the input side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is still being folded");
`endif

endmodule

// ----- test/testbench.sv -----
// testbench: self-checking bench for lcm_accumulator, the running LCM folder.
// Depends only on the RTL top level; predicts every result with a local Euclid/LCM model
// and checks each rsp_ transfer in order against it.
module testbench;

   localparam int VALUE_W      = 32;
   localparam int ACC_W        = 64;
   localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off, fills the block
   localparam int TAIL_CYCLES  = 200;    // quiet time after the last result
   localparam int STALL_LIMIT  = 60000;  // cycles with no transfer before giving up

   localparam logic [ACC_W-1:0] ACC_LIMIT = '1;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               first;
   } lcm_item_type;

   typedef struct packed {
      logic [ACC_W-1:0] lcm;
      logic             ovf;
   } lcm_result_type;

   // DUT ports; the inputs are known from time zero
   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic               req_first = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ACC_W-1:0]   rsp_lcm_value;
   logic               rsp_overflow;

   lcm_item_type   pending_items[$];     // items not yet offered
   lcm_result_type expected_results[$];  // predictions waiting for their transfer
   lcm_item_type   next_item;
   lcm_result_type run_state = '0;       // predicted accumulator and sticky flag

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   lcm_accumulator #(
      .VALUE_WIDTH(VALUE_W),
      .ACC_WIDTH  (ACC_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_first    (req_first),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_lcm_value(rsp_lcm_value),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: gcd by repeated remainder, then (acc / g) * v with
   // saturation when the product does not fit the accumulator.
   // ---------------------------------------------------------------------
   function automatic logic [ACC_W-1:0] euclid_gcd(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   function automatic lcm_result_type fold_step(input lcm_result_type now,
                                                input logic [VALUE_W-1:0] value,
                                                input logic first);
      logic [ACC_W-1:0] v;
      logic [ACC_W-1:0] g;
      logic [ACC_W-1:0] q;
      lcm_result_type   nxt;
      v   = ACC_W'(value);
      nxt = now;
      if (first) begin
         // new run: load and clear the sticky flag
         nxt.lcm = v;
         nxt.ovf = 1'b0;
      end else if (now.lcm == 0 || v == 0) begin
         nxt.lcm = '0;  // flag untouched
      end else begin
         g = euclid_gcd(now.lcm, v);
         q = now.lcm / g;
         if (q > ACC_LIMIT / v) begin
            nxt.lcm = ACC_LIMIT;
            nxt.ovf = 1'b1;
         end else begin
            nxt.lcm = q * v;
         end
      end
      return nxt;
   endfunction

   // Mostly small values keep Euclid short; full-width ones drive overflow.
   function automatic logic [VALUE_W-1:0] draw_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)       return '0;
      else if (pick < 45) return VALUE_W'($urandom_range(1, 64));
      else if (pick < 70) return VALUE_W'($urandom_range(1, 65535));
      else if (pick < 80) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      else if (pick < 83) return '1;
      else                return VALUE_W'($urandom);
   endfunction

   task automatic add_item(input logic [VALUE_W-1:0] value, input logic first);
      lcm_item_type it;
      it.value = value;
      it.first = first;
      pending_items = {pending_items, it};
   endtask

   // Sender stays quiet until every prediction has been matched.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // Random runs: a first item then a handful of folds; about one run in ten
   // drops its first item and keeps folding into the previous run.
   task automatic run_phase(input int send_pct, input int recv_pct,
                            input int n_items, input bit hold_off);
      int added;
      added          = 0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      while (added < n_items) begin
         if ($urandom_range(9) != 0) begin
            add_item(draw_value(), 1'b1);
            added++;
         end
         repeat ($urandom_range(1, 8)) begin
            add_item(draw_value(), 1'b0);
            added++;
         end
      end
      if (hold_off)
         hold_requests++;
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers pending items; payload holds while stalled. Each
   // accepted transfer is folded into the prediction right away.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         run_state = '0;
      end else begin
         if (req_valid && !req_stall) begin
            run_state = fold_step(run_state, req_value, req_first);
            expected_results = {expected_results, run_state};
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_value <= next_item.value;
               req_first <= next_item.first;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: every result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: lcm_value %h overflow %b",
                   rsp_lcm_value, rsp_overflow);
            mismatch_count++;
         end else begin
            lcm_result_type exp_res;
            exp_res = expected_results.pop_front();
            if (rsp_lcm_value !== exp_res.lcm) begin
               $error("lcm_value: expected %h, got %h", exp_res.lcm, rsp_lcm_value);
               mismatch_count++;
            end
            if (rsp_overflow !== exp_res.ovf) begin
               $error("overflow: expected %b, got %b", exp_res.ovf, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a long stretch without any transfer means the block hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, directed items, then four random phases with
   // different idling. The sequence adds items on the falling edge.
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no first item since reset: results stay zero
      add_item(32'd5, 1'b0);
      add_item(32'd0, 1'b0);
      add_item(32'hFFFF_FFFF, 1'b0);
      // plain run, then zero value and zero accumulator
      add_item(32'd12, 1'b1);
      add_item(32'd18, 1'b0);
      add_item(32'd0, 1'b0);
      add_item(32'd7, 1'b0);
      add_item(32'd0, 1'b1);
      // extremes: all-ones operands, then saturation and folds after it
      add_item(32'd1, 1'b1);
      add_item(32'hFFFF_FFFF, 1'b0);
      add_item(32'hFFFF_FFFE, 1'b0);
      add_item(32'hFFFF_FFFD, 1'b0);
      add_item(32'd3, 1'b0);
      add_item(32'd2, 1'b0);
      add_item(32'd0, 1'b0);
      // first item clears the sticky flag; top bit alone
      add_item(32'h8000_0000, 1'b1);
      add_item(32'h8000_0000, 1'b0);
      add_item(32'd3, 1'b0);
      add_item(32'hFFFF_FFFF, 1'b1);
      add_item(32'hFFFF_FFFF, 1'b0);
      // consecutive Fibonacci numbers: longest Euclid chain
      add_item(32'd2971215073, 1'b1);
      add_item(32'd1836311903, 1'b0);
      wait_drained();

      run_phase(0, 0, 232, 1'b1);    // no idling, with the long hold-off
      run_phase(78, 0, 232, 1'b0);   // sparse sender
      run_phase(0, 78, 232, 1'b0);   // slow receiver
      run_phase(19, 19, 232, 1'b0);  // both idle now and then

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- lcm_accumulator.f -----
rtl/lcma_pkg.sv
rtl/lcma_div.sv
rtl/lcma_datapath.sv
rtl/lcma_ctrl.sv
rtl/lcm_accumulator.sv
test/testbench.sv
